[src/wtam_pkg.sv]
package wtam_pkg;

  // window length in samples per channel
  localparam int WINDOW  = 3600;
  // sample width, Q8.4 degrees
  localparam int SMP_W   = 12;
  // running sum width, exact for a full window of largest samples
  localparam int TOTAL_W = 24;
  // fill count holds 0..WINDOW
  localparam int FILL_W  = $clog2(WINDOW + 1);
  // ring address
  localparam int ADDR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // divider step counter holds 0..TOTAL_W
  localparam int DCNT_W  = $clog2(TOTAL_W + 1);

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch the input word, read the slot at head
    logic update;    // write the non-zero samples, update head, fill and total
    logic start;     // clear the peaks, start the dividers, rewind the scan
    logic scan;      // step the peak scan
    logic out_load;  // move the results into the output register
  } wtam_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan_done; // scans and divisions of both channels finished
    logic out_free;  // output register empty or being taken
  } wtam_status_t;

endpackage

[src/wtam_ram.sv]
module wtam_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 3600,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/wtam_div.sv]
module wtam_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [wtam_pkg::TOTAL_W-1:0] dividend,
  input  logic [wtam_pkg::FILL_W-1:0]  divisor,
  output logic                       busy,
  output logic [wtam_pkg::TOTAL_W-1:0] quot
);

  logic [wtam_pkg::DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [wtam_pkg::TOTAL_W-1:0] dvd_r, dvd_nxt;
  logic [wtam_pkg::FILL_W-1:0]  rem_r, rem_nxt;
  logic [wtam_pkg::FILL_W-1:0]  dsr_r, dsr_nxt;
  logic [wtam_pkg::FILL_W:0]    shifted;
  logic                         ge;

  // restoring division, one quotient bit a step, quotient shifts into dvd_r
  always_comb begin
    shifted = {rem_r, dvd_r[wtam_pkg::TOTAL_W-1]};
    ge      = shifted >= {1'b0, dsr_r};
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    if (start) begin
      cnt_nxt = wtam_pkg::DCNT_W'(wtam_pkg::TOTAL_W);
      dvd_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - wtam_pkg::DCNT_W'(1);
      dvd_nxt = {dvd_r[wtam_pkg::TOTAL_W-2:0], ge};
      rem_nxt = ge ? wtam_pkg::FILL_W'(shifted - {1'b0, dsr_r})
                   : wtam_pkg::FILL_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy = cnt_r != '0;
  assign quot = dvd_r;

endmodule

[src/wtam_chan.sv]
module wtam_chan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wtam_pkg::wtam_cmd_t         cmd,
  input  logic [wtam_pkg::SMP_W-1:0]  smp,
  output logic [wtam_pkg::SMP_W-1:0]  mean,
  output logic [wtam_pkg::SMP_W-1:0]  peak,
  output logic                        done
);

  logic [wtam_pkg::ADDR_W-1:0]  head_r, head_nxt;
  logic [wtam_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  logic [wtam_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [wtam_pkg::FILL_W-1:0]  scan_addr_r, scan_addr_nxt;
  logic                         rd_pend_r, rd_pend_nxt;
  logic [wtam_pkg::SMP_W-1:0]   peak_r, peak_nxt;
  logic [wtam_pkg::ADDR_W-1:0]  raddr;
  logic [wtam_pkg::SMP_W-1:0]   rdata;
  logic                         we;
  logic                         full;
  logic                         scan_more;
  logic                         div_busy;
  logic [wtam_pkg::TOTAL_W-1:0] quot;

  wtam_ram #(
    .WIDTH (wtam_pkg::SMP_W),
    .DEPTH (wtam_pkg::WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (head_r),
    .wdata (smp),
    .raddr (raddr),
    .rdata (rdata)
  );

  wtam_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start),
    .dividend (total_r),
    .divisor  (fill_r),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign full      = fill_r == wtam_pkg::FILL_W'(wtam_pkg::WINDOW);
  assign we        = cmd.update && (smp != '0);
  assign scan_more = scan_addr_r < fill_r;
  // until the ring wraps the window sits at 0..fill-1, once full it is all of it
  assign raddr     = cmd.scan ? scan_addr_r[wtam_pkg::ADDR_W-1:0] : head_r;

  always_comb begin
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    scan_addr_nxt = scan_addr_r;
    rd_pend_nxt   = 1'b0;
    peak_nxt      = peak_r;
    if (we) begin
      // rdata holds the slot at head, read when the word was taken
      fill_nxt  = full ? fill_r : fill_r + wtam_pkg::FILL_W'(1);
      total_nxt = total_r - (full ? wtam_pkg::TOTAL_W'(rdata) : '0)
                  + wtam_pkg::TOTAL_W'(smp);
      head_nxt  = (head_r == wtam_pkg::ADDR_W'(wtam_pkg::WINDOW - 1))
                  ? '0 : head_r + wtam_pkg::ADDR_W'(1);
    end
    if (cmd.start) begin
      scan_addr_nxt = '0;
      peak_nxt      = '0;
    end else begin
      if (cmd.scan && scan_more) begin
        scan_addr_nxt = scan_addr_r + wtam_pkg::FILL_W'(1);
        rd_pend_nxt   = 1'b1;
      end
      if (rd_pend_r && (rdata > peak_r)) begin
        peak_nxt = rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      fill_r    <= '0;
      total_r   <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      total_r   <= total_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    peak_r      <= peak_nxt;
  end

  assign done = !div_busy && !rd_pend_r && !scan_more;
  assign mean = (fill_r == '0) ? '0 : quot[wtam_pkg::SMP_W-1:0];
  assign peak = peak_r;

endmodule

[src/wtam_dp.sv]
module wtam_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wtam_pkg::wtam_cmd_t           cmd,
  output wtam_pkg::wtam_status_t        status,
  input  logic [2*wtam_pkg::SMP_W-1:0]  in_word,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [4*wtam_pkg::SMP_W-1:0]  out_tdata
);

  logic [wtam_pkg::SMP_W-1:0]   cpu_smp_r, gpu_smp_r;
  logic [wtam_pkg::SMP_W-1:0]   cpu_mean, cpu_peak, gpu_mean, gpu_peak;
  logic                         cpu_done, gpu_done;
  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [4*wtam_pkg::SMP_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cpu_smp_r <= in_word[wtam_pkg::SMP_W-1:0];
      gpu_smp_r <= in_word[2*wtam_pkg::SMP_W-1:wtam_pkg::SMP_W];
    end
  end

  wtam_chan u_cpu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .smp   (cpu_smp_r),
    .mean  (cpu_mean),
    .peak  (cpu_peak),
    .done  (cpu_done)
  );

  wtam_chan u_gpu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .smp   (gpu_smp_r),
    .mean  (gpu_mean),
    .peak  (gpu_peak),
    .done  (gpu_done)
  );

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata_r <= {gpu_peak, gpu_mean, cpu_peak, cpu_mean};
    end
  end

  assign status.scan_done = cpu_done && gpu_done;
  assign status.out_free  = !out_tvalid_r || out_tready;
  assign out_tvalid       = out_tvalid_r;
  assign out_tdata        = out_tdata_r;

endmodule

[src/wtam_ctrl.sv]
module wtam_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  wtam_pkg::wtam_status_t status,
  output wtam_pkg::wtam_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_UPD   = 5'b00010,
    ST_START = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DONE  = 5'b10000
  } wtam_state_t;

  wtam_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_START;
      end
      ST_START: begin
        cmd.start = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/windowed_temp_avg_max.sv]
// sliding window mean and maximum of two temperature channels. each input word
// carries a cpu and a gpu sample in unsigned q8.4 degrees; a non-zero sample is
// appended to its channel's window of the last 3600 samples (the oldest drops
// out once full), a zero sample leaves the window alone. every word yields one
// result word with the truncated mean and the peak of each window, both zero
// while a window is empty. one word is worked at a time; the peak scan reads
// each ring memory one entry a cycle, and the 24-step serial divider runs
// alongside it. a new input word is taken while the previous result still
// waits in the output register. no clearing pass is needed after reset.
module windowed_temp_avg_max (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cpu_sample [11:0], gpu_sample [23:12]
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cpu_mean [11:0], cpu_peak [23:12], gpu_mean [35:24], gpu_peak [47:36]
  output logic [47:0] out_tdata
);

  // command and status between the sequencer and the datapath
  wtam_pkg::wtam_cmd_t    cmd;
  wtam_pkg::wtam_status_t status;

  // sequencer: take word, update rings, scan and divide, hand over result
  wtam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: two channel units and the output register
  wtam_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_word    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[src/wtam_chk.sv]
module wtam_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one word at a time: no new word right after one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a word");

  // cpu peak never below mean, and both zero together
  a_cpu_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:12] >= out_tdata[11:0])
                   && ((out_tdata[23:12] == 12'd0) == (out_tdata[11:0] == 12'd0)))
    else $error("cpu peak and mean inconsistent");

  // gpu peak never below mean, and both zero together
  a_gpu_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[47:36] >= out_tdata[35:24])
                   && ((out_tdata[47:36] == 12'd0) == (out_tdata[35:24] == 12'd0)))
    else $error("gpu peak and mean inconsistent");

endmodule

bind windowed_temp_avg_max wtam_chk u_chk (.*);
